/* src/dcp_pkg.sv */
// Shared types, widths and helpers for the distance constraint projection core.
// No dependencies; every other file imports this package.
package dcp_pkg;

  localparam int unsigned POS_W      = 32;
  localparam int unsigned CFG_W      = 31;
  localparam int unsigned IDX_W      = 2;
  localparam int unsigned SQ_W       = 64;
  localparam int unsigned SUM_W      = 66;
  localparam int unsigned SQRT_STEPS = 33;
  localparam int unsigned ROOT_W     = 33;
  localparam int unsigned REM_W      = 36;
  localparam int unsigned DIST_W     = 33;
  localparam int unsigned DEV_W      = 34;
  localparam int unsigned DREM_W     = 34;
  localparam int unsigned EXT_W      = 35;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_REST_LENGTH = 2'd0,
    REG_LIFT_FORCE  = 2'd1
  } cfg_reg_e;

  // Positions and flags that ride along the whole pipeline
  typedef struct packed {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] cx;
    logic signed [POS_W-1:0] cy;
    logic                    neg_x;
    logic                    neg_y;
    logic                    degen;
  } pos_t;

  // State of one square root cell
  typedef struct packed {
    logic [SUM_W-1:0]  s;
    logic [ROOT_W-1:0] root;
    logic [REM_W-1:0]  rem;
  } sqrt_t;

  // Clamp a widened sum to the signed position range
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [EXT_W-1:0] v);
    logic signed [EXT_W-1:0] hi;
    logic signed [EXT_W-1:0] lo;
    hi = EXT_W'(32'sh7FFF_FFFF);
    lo = -EXT_W'(33'sh0_8000_0000);
    if (v > hi) begin
      sat_pos = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat_pos = 32'sh8000_0000;
    end else begin
      sat_pos = v[POS_W-1:0];
    end
  endfunction

endpackage

/* src/dcp_sqrt_cell.sv */
// One digit-pair step of the restoring integer square root.
// Depends on dcp_pkg for the sqrt_t cell state.
module dcp_sqrt_cell (
  input  logic            clk_i,
  input  logic            en_i,
  input  dcp_pkg::sqrt_t  st_i,
  output dcp_pkg::sqrt_t  st_o
);
  import dcp_pkg::*;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             ge;
  sqrt_t            st_d, st_q;

  // Bring down the next bit pair and try the subtraction
  always_comb begin
    rem_sh    = {st_i.rem[REM_W-3:0], st_i.s[SUM_W-1:SUM_W-2]};
    trial     = {1'b0, st_i.root, 2'b01};
    ge        = (rem_sh >= trial);
    st_d.s    = {st_i.s[SUM_W-3:0], 2'b00};
    st_d.rem  = ge ? (rem_sh - trial) : rem_sh;
    st_d.root = {st_i.root[ROOT_W-2:0], ge};
  end

  // Hand the state to the next cell
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign st_o = st_q;

endmodule

/* src/dcp_div_cell.sv */
// One quotient bit of the restoring division for both axes.
// Depends on dcp_pkg for widths.
module dcp_div_cell #(
  parameter int unsigned QW = 17
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [dcp_pkg::DIST_W-1:0] dist_i,
  input  logic [dcp_pkg::DREM_W-1:0] rem_x_i,
  input  logic [dcp_pkg::DREM_W-1:0] rem_y_i,
  input  logic [QW-1:0]              q_x_i,
  input  logic [QW-1:0]              q_y_i,
  output logic [dcp_pkg::DIST_W-1:0] dist_o,
  output logic [dcp_pkg::DREM_W-1:0] rem_x_o,
  output logic [dcp_pkg::DREM_W-1:0] rem_y_o,
  output logic [QW-1:0]              q_x_o,
  output logic [QW-1:0]              q_y_o
);
  import dcp_pkg::*;

  logic [DREM_W-1:0] dvs;
  logic              ge_x, ge_y;
  logic [DREM_W-1:0] r_x, r_y;

  // Compare and subtract the divisor, then shift for the next bit
  always_comb begin
    dvs  = {1'b0, dist_i};
    ge_x = (rem_x_i >= dvs);
    ge_y = (rem_y_i >= dvs);
    r_x  = ge_x ? (rem_x_i - dvs) : rem_x_i;
    r_y  = ge_y ? (rem_y_i - dvs) : rem_y_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dist_o  <= dist_i;
      rem_x_o <= {r_x[DREM_W-2:0], 1'b0};
      rem_y_o <= {r_y[DREM_W-2:0], 1'b0};
      q_x_o   <= {q_x_i[QW-2:0], ge_x};
      q_y_o   <= {q_y_i[QW-2:0], ge_y};
    end
  end

endmodule

/* src/distance_constraint_projection_core.sv */
// Top level: pipelined distance constraint projection for one body pair a cycle.
// Depends on dcp_pkg, dcp_sqrt_cell and dcp_div_cell.
//
//  channel  | direction | payload
//  s_axis   | in        | tdata: parent_x, parent_y, child_x, child_y
//  m_axis   | out       | tdata: new positions, forces; tuser: degenerate
//  cfg      | in        | write enable, index, 31-bit data
//
// One pair enters every cycle while m_axis is not stalled; the chain holds the
// 33 square root cells and the FRAC_BITS + 1 divider cells.
// Reset clears only the valid bits and sets the two registers to their defaults.
// The whole chain holds while a result waits at m_axis; s_axis_tready follows.
module distance_constraint_projection_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [127:0]                s_axis_tdata,  // parent_x, parent_y, child_x, child_y
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // new_parent_x, new_parent_y, new_child_x, new_child_y, parent_force_y, child_force_y
  output logic [191:0]                m_axis_tdata,
  output logic                        m_axis_tuser,  // degenerate
  input  logic                        cfg_we_i,
  input  logic [dcp_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [dcp_pkg::CFG_W-1:0]   cfg_wdata_i
);
  import dcp_pkg::*;

  localparam int unsigned QW      = FRAC_BITS + 1;
  localparam int unsigned ST_SQ0  = 3;
  localparam int unsigned ST_DEV  = ST_SQ0 + SQRT_STEPS;
  localparam int unsigned ST_DIV0 = ST_DEV + 1;
  localparam int unsigned ST_MUL  = ST_DIV0 + QW;
  localparam int unsigned NP      = ST_MUL + 1;
  localparam int unsigned PROD_W  = QW + DEV_W;

  logic               en;
  logic               accept;
  logic [CFG_W-1:0]   rest_q, lift_q;
  logic               v_q   [NP];
  pos_t               pos_q [NP];
  pos_t               pos_d;
  logic [POS_W-1:0]   ax_q [ST_DEV+1];
  logic [POS_W-1:0]   ay_q [ST_DEV+1];
  logic [POS_W-1:0]   ax_d, ay_d;
  logic [POS_W:0]     dx, dy;
  logic [SQ_W-1:0]    sqx_q, sqy_q;
  logic [SUM_W-1:0]   sum_q;
  sqrt_t              sq_in  [SQRT_STEPS];
  sqrt_t              sq_out [SQRT_STEPS];
  logic [DEV_W-1:0]   dev;
  logic [DIST_W-1:0]  dist_q;
  logic [DEV_W-1:0]   mdev_q [ST_DEV:ST_MUL-1];
  logic               dneg_q [ST_DEV:ST_MUL];
  logic [DIST_W-1:0]  dv_dist [QW];
  logic [DREM_W-1:0]  dv_rx [QW];
  logic [DREM_W-1:0]  dv_ry [QW];
  logic [QW-1:0]      dv_qx [QW];
  logic [QW-1:0]      dv_qy [QW];
  logic [PROD_W-1:0]  prod_x_q, prod_y_q;
  logic [DEV_W-1:0]   cor_x, cor_y;
  logic signed [EXT_W-1:0] kx, ky;
  logic               neg_cx, neg_cy;
  logic               out_v_q;
  logic [127:0]       out_data_q;
  logic               out_degen_q;
  pos_t               last;

  // Advance the whole chain unless a result is stuck at the output
  assign en            = !out_v_q || m_axis_tready;
  assign accept        = s_axis_tvalid && en;
  assign s_axis_tready = en;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_q <= 31'd3276800;
      lift_q <= 31'd64225;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_REST_LENGTH: rest_q <= cfg_wdata_i;
        REG_LIFT_FORCE:  lift_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Stage 0: differences and magnitudes
  always_comb begin
    pos_d.px    = s_axis_tdata[31:0];
    pos_d.py    = s_axis_tdata[63:32];
    pos_d.cx    = s_axis_tdata[95:64];
    pos_d.cy    = s_axis_tdata[127:96];
    dx          = {pos_d.cx[31], pos_d.cx} - {pos_d.px[31], pos_d.px};
    dy          = {pos_d.cy[31], pos_d.cy} - {pos_d.py[31], pos_d.py};
    ax_d        = dx[POS_W] ? POS_W'(-dx) : dx[POS_W-1:0];
    ay_d        = dy[POS_W] ? POS_W'(-dy) : dy[POS_W-1:0];
    pos_d.neg_x = dx[POS_W];
    pos_d.neg_y = dy[POS_W];
    pos_d.degen = (dx == '0) && (dy == '0);
  end

  // Valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NP; k++) v_q[k] <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v_q[0] <= accept;
      for (int k = 1; k < NP; k++) v_q[k] <= v_q[k-1];
      out_v_q <= v_q[NP-1];
    end
  end

  // Payload chain
  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_q[0] <= pos_d;
      for (int k = 1; k < NP; k++) pos_q[k] <= pos_q[k-1];
      ax_q[0] <= ax_d;
      ay_q[0] <= ay_d;
      for (int k = 1; k <= ST_DEV; k++) begin
        ax_q[k] <= ax_q[k-1];
        ay_q[k] <= ay_q[k-1];
      end
      sqx_q <= ax_q[0] * ax_q[0];
      sqy_q <= ay_q[0] * ay_q[0];
      sum_q <= SUM_W'(sqx_q) + SUM_W'(sqy_q);
    end
  end

  // Square root chain
  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    if (g == 0) begin : g_first
      always_comb begin
        sq_in[g].s    = sum_q;
        sq_in[g].root = '0;
        sq_in[g].rem  = '0;
      end
    end else begin : g_next
      assign sq_in[g] = sq_out[g-1];
    end
    dcp_sqrt_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .st_i  (sq_in[g]),
      .st_o  (sq_out[g])
    );
  end

  // Deviation from rest length
  assign dev = {1'b0, sq_out[SQRT_STEPS-1].root} - {3'b000, rest_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q         <= sq_out[SQRT_STEPS-1].root;
      mdev_q[ST_DEV] <= dev[DEV_W-1] ? DEV_W'(-dev) : dev;
      dneg_q[ST_DEV] <= dev[DEV_W-1];
      for (int k = ST_DEV + 1; k < ST_MUL; k++) mdev_q[k] <= mdev_q[k-1];
      for (int k = ST_DEV + 1; k <= ST_MUL; k++) dneg_q[k] <= dneg_q[k-1];
    end
  end

  // Divider chain: unit vector components, one bit a cell
  for (genvar g = 0; g < QW; g++) begin : g_div
    if (g == 0) begin : g_first
      dcp_div_cell #(.QW(QW)) u_cell (
        .clk_i   (clk_i),
        .en_i    (en),
        .dist_i  (dist_q),
        .rem_x_i ({2'b00, ax_q[ST_DEV]}),
        .rem_y_i ({2'b00, ay_q[ST_DEV]}),
        .q_x_i   ('0),
        .q_y_i   ('0),
        .dist_o  (dv_dist[g]),
        .rem_x_o (dv_rx[g]),
        .rem_y_o (dv_ry[g]),
        .q_x_o   (dv_qx[g]),
        .q_y_o   (dv_qy[g])
      );
    end else begin : g_next
      dcp_div_cell #(.QW(QW)) u_cell (
        .clk_i   (clk_i),
        .en_i    (en),
        .dist_i  (dv_dist[g-1]),
        .rem_x_i (dv_rx[g-1]),
        .rem_y_i (dv_ry[g-1]),
        .q_x_i   (dv_qx[g-1]),
        .q_y_i   (dv_qy[g-1]),
        .dist_o  (dv_dist[g]),
        .rem_x_o (dv_rx[g]),
        .rem_y_o (dv_ry[g]),
        .q_x_o   (dv_qx[g]),
        .q_y_o   (dv_qy[g])
      );
    end
  end

  // Scale unit vector by the deviation
  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_x_q <= PROD_W'(dv_qx[QW-1]) * PROD_W'(mdev_q[ST_MUL-1]);
      prod_y_q <= PROD_W'(dv_qy[QW-1]) * PROD_W'(mdev_q[ST_MUL-1]);
    end
  end

  // Halve, sign and apply the correction
  always_comb begin
    last   = pos_q[NP-1];
    cor_x  = prod_x_q[PROD_W-1:QW];
    cor_y  = prod_y_q[PROD_W-1:QW];
    neg_cx = last.neg_x ^ dneg_q[ST_MUL];
    neg_cy = last.neg_y ^ dneg_q[ST_MUL];
    kx     = neg_cx ? -$signed({1'b0, cor_x}) : $signed({1'b0, cor_x});
    ky     = neg_cy ? -$signed({1'b0, cor_y}) : $signed({1'b0, cor_y});
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_degen_q <= last.degen;
      if (last.degen) begin
        out_data_q <= {last.cy, last.cx, last.py, last.px};
      end else begin
        out_data_q[31:0]   <= sat_pos(EXT_W'(last.px) + kx);
        out_data_q[63:32]  <= sat_pos(EXT_W'(last.py) + ky);
        out_data_q[95:64]  <= sat_pos(EXT_W'(last.cx) - kx);
        out_data_q[127:96] <= sat_pos(EXT_W'(last.cy) - ky);
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {POS_W'(-{1'b0, lift_q}), {1'b0, lift_q}, out_data_q};
  assign m_axis_tuser  = out_degen_q;

`ifndef ASSERT_OFF
  // Forces always come out as an opposite pair
  a_force_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[159:128] + m_axis_tdata[191:160] == 32'd0))
    else $error("force fields are not opposite");

  // A stall freezes the valid chain
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_q[NP-1]) && $stable(v_q[0]))
    else $error("pipeline moved during stall");

  // Degenerate flag agrees with the squared distance
  a_degen_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[2] |-> ((sum_q == '0) == pos_q[2].degen))
    else $error("degenerate flag mismatch");
`endif

endmodule

/* bench/dcp_scoreboard.sv */
// Checker for the distance constraint projection core: watches the stream and config ports,
// predicts each corrected pair and compares it with what comes out. Depends on dcp_pkg.
`timescale 1ns / 100ps
module dcp_scoreboard #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      s_axis_tvalid,
  input  logic                      s_axis_tready,
  input  logic [127:0]              s_axis_tdata,
  input  logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  input  logic [191:0]              m_axis_tdata,
  input  logic                      m_axis_tuser,
  input  logic                      cfg_we_i,
  input  logic [dcp_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [dcp_pkg::CFG_W-1:0] cfg_wdata_i,
  output int                        errors_o,
  output int                        pending_o
);
  import dcp_pkg::*;

  localparam int unsigned PTR_W = 7;
  localparam int unsigned DEPTH = 1 << PTR_W;

  typedef struct packed {
    logic [191:0] data;
    logic         degen;
  } pair_result_t;

  logic [CFG_W-1:0] rest_len;
  logic [CFG_W-1:0] lift;
  pair_result_t     want_mem [DEPTH];
  int               wr_cnt;
  int               rd_cnt;
  int               errors;

  initial begin
    rest_len = 31'd3276800;
    lift     = 31'd64225;
    errors   = 0;
    wr_cnt   = 0;
    rd_cnt   = 0;
  end

  assign errors_o  = errors;
  assign pending_o = wr_cnt - rd_cnt;

  // floor of the square root of a 66-bit sum, two bits per step
  function automatic logic [63:0] int_sqrt(input logic [65:0] s);
    logic [67:0] rem;
    logic [67:0] root;
    logic [67:0] trial;
    rem  = '0;
    root = '0;
    for (int i = 32; i >= 0; i--) begin
      rem   = (rem << 2) | 68'(s[2*i +: 2]);
      trial = (root << 2) | 68'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 68'd1;
      end else begin
        root = root << 1;
      end
    end
    return root[63:0];
  endfunction

  function automatic longint shift_along(input longint d, input logic [63:0] len,
                                         input longint dev);
    logic [63:0] dmag;
    logic [63:0] devmag;
    logic [63:0] u;
    logic [63:0] c;
    dmag   = d < 0 ? 64'(-d) : 64'(d);
    devmag = dev < 0 ? 64'(-dev) : 64'(dev);
    u      = (dmag << FRAC_BITS) / len;
    c      = (u * devmag) >> (FRAC_BITS + 1);
    return ((d < 0) != (dev < 0)) ? -longint'(c) : longint'(c);
  endfunction

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic pair_result_t project_pair(input logic [127:0] d);
    pair_result_t r;
    longint       px, py, cx, cy, dx, dy, kx, ky, dev;
    logic [65:0]  sum;
    logic [63:0]  link_len;
    px  = longint'($signed(d[31:0]));
    py  = longint'($signed(d[63:32]));
    cx  = longint'($signed(d[95:64]));
    cy  = longint'($signed(d[127:96]));
    dx  = cx - px;
    dy  = cy - py;
    sum = 66'($unsigned(dx * dx)) + 66'($unsigned(dy * dy));
    link_len = int_sqrt(sum);
    r.data[159:128] = {1'b0, lift};
    r.data[191:160] = -{1'b0, lift};
    if (link_len == 0) begin
      r.data[127:0] = d;
      r.degen       = 1'b1;
    end else begin
      dev = longint'(link_len) - longint'(rest_len);
      kx  = shift_along(dx, link_len, dev);
      ky  = shift_along(dy, link_len, dev);
      r.data[31:0]   = clamp32(px + kx);
      r.data[63:32]  = clamp32(py + ky);
      r.data[95:64]  = clamp32(cx - kx);
      r.data[127:96] = clamp32(cy - ky);
      r.degen        = 1'b0;
    end
    return r;
  endfunction

  // Track registers, compare results, queue predictions
  always @(posedge clk_i) begin
    pair_result_t want;
    if (cfg_we_i) begin
      if (cfg_idx_i == REG_REST_LENGTH) rest_len <= cfg_wdata_i;
      else if (cfg_idx_i == REG_LIFT_FORCE) lift <= cfg_wdata_i;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      if (wr_cnt == rd_cnt) begin
        errors++;
        $display("%0t: unexpected result beat, actual %h user %b", $time, m_axis_tdata,
                 m_axis_tuser);
      end else begin
        want = want_mem[rd_cnt[PTR_W-1:0]];
        rd_cnt++;
        for (int f = 0; f < 6; f++) begin
          if (want.data[32*f +: 32] !== m_axis_tdata[32*f +: 32]) begin
            errors++;
            $display("%0t: field %0d mismatch, expected %h actual %h", $time, f,
                     want.data[32*f +: 32], m_axis_tdata[32*f +: 32]);
          end
        end
        if (want.degen !== m_axis_tuser) begin
          errors++;
          $display("%0t: degenerate mismatch, expected %b actual %b", $time, want.degen,
                   m_axis_tuser);
        end
      end
    end
    if (s_axis_tvalid && s_axis_tready) begin
      if (wr_cnt - rd_cnt >= DEPTH) begin
        errors++;
        $display("%0t: prediction store overflow, expected at most %0d actual %0d", $time,
                 DEPTH, wr_cnt - rd_cnt + 1);
      end else begin
        want_mem[wr_cnt[PTR_W-1:0]] = project_pair(s_axis_tdata);
        wr_cnt++;
      end
    end
  end

endmodule

/* bench/distance_constraint_projection_core_tb.sv */
// Testbench top for distance_constraint_projection_core: drives pairs and config writes,
// applies backpressure and gives the verdict. Depends on dcp_pkg and dcp_scoreboard.
`timescale 1ns / 100ps
module distance_constraint_projection_core_tb;
  import dcp_pkg::*;

  localparam int unsigned FRAC_BITS = 16;
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 280;
  localparam int NUM_PHASES  = 6;
  localparam int DRAIN_WAIT  = FRAC_BITS + 60;
  localparam int STALL_LIMIT = 5000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [127:0]       s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [191:0]       m_axis_tdata;
  logic               m_axis_tuser;
  logic               cfg_we_i = 1'b0;
  logic [IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_W-1:0]   cfg_wdata_i = '0;
  int                 errors;
  int                 pending;
  int                 sent = 0;
  bit                 idling = 1'b1;
  int                 quiet_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  distance_constraint_projection_core #(.FRAC_BITS(FRAC_BITS)) DUT (.*);

  dcp_scoreboard #(.FRAC_BITS(FRAC_BITS)) u_scoreboard (
    .clk_i, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .m_axis_tvalid,
    .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .cfg_we_i, .cfg_idx_i,
    .cfg_wdata_i, .errors_o(errors), .pending_o(pending)
  );

  // Offer one pair, after an optional idle burst; hold until accepted
  task automatic send_pair(input logic [31:0] px, py, cx, cy);
    if (idling && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {cy, cx, py, px};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent++;
  endtask

  // Write both registers and one unused index, then drop the enable
  task automatic write_regs(input logic [CFG_W-1:0] rest, lift, junk);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_REST_LENGTH;
    cfg_wdata_i <= rest;
    @(posedge clk_i);
    cfg_idx_i <= REG_LIFT_FORCE;
    cfg_wdata_i <= lift;
    @(posedge clk_i);
    cfg_idx_i <= REG_UNUSED;
    cfg_wdata_i <= junk;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Mostly nearby pairs for a meaningful correction; also coinciding, extremes, noise
  task automatic send_random;
    logic [31:0] px, py, cx, cy;
    int          span;
    px = $urandom;
    py = $urandom;
    case ($urandom_range(0, 19))
      0, 1: begin
        cx = px;
        cy = py;
      end
      2, 3, 4: begin
        px = pick_coord(); py = pick_coord(); cx = pick_coord(); cy = pick_coord();
      end
      5, 6: begin
        cx = $urandom;
        cy = $urandom;
      end
      default: begin
        span = $urandom_range(4, 26);
        cx = px + 32'($signed($urandom_range(0, (1 << span) - 1)) - (1 << (span - 1)));
        cy = py + 32'($signed($urandom_range(0, (1 << span) - 1)) - (1 << (span - 1)));
      end
    endcase
    send_pair(px, py, cx, cy);
  endtask

  // Receiver: random stall bursts, one long hold-off mid run
  initial begin
    int  burst;
    int  hold;
    bit  held;
    burst = 0;
    hold  = 0;
    held  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && sent >= 600) begin
        held = 1'b1;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        m_axis_tready <= 1'b0;
      end else if (idling && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(0, 11);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no accepted beat
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: coinciding bodies, extremes, rest length hits, saturation
    send_pair(32'h0, 32'h0, 32'h0, 32'h0);
    send_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_pair(32'h0, 32'h0, 32'h0032_0000, 32'h0);
    send_pair(32'h0, 32'h0, 32'h0, 32'hFFCE_0000);
    send_pair(32'h0, 32'h0, 32'h0001_0000, 32'h0);
    send_pair(32'h0, 32'h0, 32'h1000_0000, 32'h0);
    send_pair(32'h0, 32'h0, 32'h0, 32'h1);
    send_pair(32'h0, 32'h0, 32'h1, 32'h1);
    send_pair(32'h7FFF_FFF0, 32'h0, 32'h7FFF_FFFF, 32'h0);
    send_pair(32'h8000_0010, 32'h0, 32'h8000_0000, 32'h0);
    send_pair(32'h0, 32'h7FFF_FFFF, 32'h0, 32'h7FF0_0000);
    send_pair(32'h1234_5678, 32'h9ABC_DEF0, 32'h1234_5678, 32'h9ABC_DEF0);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_pair(32'h0018_0000, 32'hFFE8_0000, 32'hFFE8_0000, 32'h0018_0000);
    drain();
    write_regs(31'h0, 31'h7FFF_FFFF, 31'h5555_5555);
    send_pair(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000);
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_pair(32'h0, 32'h0, 32'h0, 32'h0);
    drain();
    write_regs(31'h7FFF_FFFF, 31'h0, 31'h2AAA_AAAA);
    send_pair(32'h0, 32'h0, 32'h0001_0000, 32'h0);
    send_pair(32'h7FF0_0000, 32'h0, 32'h8010_0000, 32'h0);
    drain();

    // Random phases, each with its own register setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: write_regs(31'd3276800, 31'd64225, CFG_W'($urandom));
        1: write_regs(CFG_W'($urandom_range(0, 32'h00FF_FFFF)), CFG_W'($urandom),
                      CFG_W'($urandom));
        2: write_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF, CFG_W'($urandom));
        3: write_regs(31'h0, 31'h0, CFG_W'($urandom));
        default: write_regs(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
      endcase
      idling = (ph != NUM_PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) send_random();
      drain();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
